// ===== src/hbp_pkg.sv =====
// Shared constants and types of the Huffman bit packer.
package hbp_pkg;

    localparam int SYM_W            = 8;
    localparam int TABLE_DEPTH      = 256;
    localparam int WORD_BITS        = 32;
    localparam int LEN_IN_W         = 6;
    localparam int BYTE_BITS        = 8;
    localparam int DEF_MAX_CODE_LEN = 32;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_PACK   = 4'b0100,
        S_FLUSH  = 4'b1000
    } t_state;

endpackage

// ===== src/huffman_bit_packer_top.sv =====
// Huffman encoder back end: code table plus MSB-first byte packer.
// Load: writes the table entry. Encode: reads the table in S_LOOKUP, then S_PACK
// emits each of N completed bytes (0..4) and parks the remaining bits.
// Flush: S_FLUSH emits pending bits, if any. Output stalls hold the sequencer.
// Synchronous active-low reset clears the sequencer, accumulator, output
// valid flag and all 256 length valid bits; the code word RAM is not cleared.
module huffman_bit_packer_top
    import hbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_mode,
    input  logic [SYM_W-1:0]     i_symbol,
    input  logic [LEN_IN_W-1:0]  i_code_length,
    input  logic [WORD_BITS-1:0] i_code_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_packed_byte,
    output logic                 o_last_of_run
);

    // Effective length limit: the code word port is only WORD_BITS wide.
    localparam int LEN_LIM = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam int LEN_W   = $clog2(LEN_LIM + 1);
    localparam int AV_W    = LEN_W + 1;
    localparam int RAM_W   = WORD_BITS + LEN_W;
    localparam logic [LEN_IN_W-1:0] LEN_LIM_IN = LEN_IN_W'(LEN_LIM);

    t_state r_state, n_state;

    // Bit accumulator: pending bits sit left-aligned in r_acc.
    logic [7:0]           r_acc, n_acc;
    logic [2:0]           r_cnt, n_cnt;
    // Code being packed, left-aligned, and its remaining bit count.
    logic [WORD_BITS-1:0] r_code, n_code;
    logic [LEN_W-1:0]     r_rem, n_rem;

    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_byte, n_out_byte;
    logic                 r_out_last, n_out_last;

    logic [TABLE_DEPTH-1:0] r_len_valid;
    logic [SYM_W-1:0]       r_sym;

    logic                 accept;
    logic                 slot_free;
    logic                 load_we;
    logic [LEN_IN_W-1:0]  sat_len;
    logic [RAM_W-1:0]     ram_wdata;
    logic [RAM_W-1:0]     ram_rdata;
    logic [LEN_W-1:0]     look_len;
    logic [5:0]           align_sh;

    logic [7:0]           merged;
    logic [AV_W-1:0]      avail;
    logic [3:0]           take;
    logic [LEN_W-1:0]     new_rem;
    logic [WORD_BITS-1:0] shifted;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    // Table write: saturate the length to the limit before storing it.
    assign sat_len   = (i_code_length > LEN_LIM_IN) ? LEN_LIM_IN : i_code_length;
    assign load_we   = accept && (i_mode == MODE_LOAD);
    assign ram_wdata = {LEN_W'(sat_len), i_code_word};

    hbp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_symbol),
        .i_wdata (ram_wdata),
        .i_raddr (i_symbol),
        .o_rdata (ram_rdata)
    );

    // An entry never loaded reads as length zero.
    assign look_len = r_len_valid[r_sym] ? ram_rdata[RAM_W-1 -: LEN_W] : '0;
    assign align_sh = 6'(WORD_BITS) - 6'(look_len);

    // Shared pack unit: top code bits fill the free accumulator positions.
    assign merged  = r_acc | (r_code[WORD_BITS-1 -: 8] >> r_cnt);
    assign avail   = AV_W'(r_cnt) + AV_W'(r_rem);
    assign take    = 4'(BYTE_BITS) - 4'(r_cnt);
    assign new_rem = r_rem - LEN_W'(take);
    assign shifted = r_code << take;

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_code      = r_code;
        n_rem       = r_rem;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_ENCODE: n_state = S_LOOKUP;
                        MODE_FLUSH: begin
                            if (r_cnt != 3'd0) begin
                                n_state = S_FLUSH;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP: begin
                // Left-align the code so its first bit sits at the top.
                n_code = ram_rdata[WORD_BITS-1:0] << align_sh;
                n_rem  = look_len;
                if (look_len == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PACK;
                end
            end
            S_PACK: begin
                if (avail >= AV_W'(BYTE_BITS)) begin
                    // A byte completes: hold until the output slot is free.
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = merged;
                        n_out_last  = (new_rem < LEN_W'(BYTE_BITS));
                        if (new_rem < LEN_W'(BYTE_BITS)) begin
                            n_acc   = shifted[WORD_BITS-1 -: 8];
                            n_cnt   = new_rem[2:0];
                            n_state = S_IDLE;
                        end else begin
                            n_acc  = '0;
                            n_cnt  = '0;
                            n_code = shifted;
                            n_rem  = new_rem;
                        end
                    end
                end else begin
                    // Remaining bits fit in the accumulator: park them.
                    n_acc   = merged;
                    n_cnt   = avail[2:0];
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_acc;
                    n_out_last  = 1'b1;
                    n_acc       = '0;
                    n_cnt       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_len_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (load_we) begin
                r_len_valid[i_symbol] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_rem      <= n_rem;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        if (accept) begin
            r_sym <= i_symbol;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_packed_byte = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

// ===== src/hbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/hbp_checker.sv =====
// Port-level checks of the Huffman bit packer, bound to its top level.
module hbp_checker
    import hbp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_mode,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_packed_byte,
    input logic       o_last_of_run
);

    // Hold a stalled result unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_packed_byte) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // An encode request always occupies the table read cycle.
    a_encode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_mode == MODE_ENCODE |=> !o_in_ready)
        else $error("ready after encode request");

    // Load and unknown requests leave the block ready again in the next cycle.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode == MODE_LOAD || i_mode == MODE_NONE)
            |=> o_in_ready)
        else $error("load request held the block");

    // A result cannot appear from a load request alone.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && i_in_valid && o_in_ready && i_mode == MODE_LOAD
            |=> !o_out_valid)
        else $error("load request produced a byte");

endmodule

bind huffman_bit_packer_top hbp_checker u_hbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_mode        (i_mode),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_packed_byte (o_packed_byte),
    .o_last_of_run (o_last_of_run)
);
